// ===== hdl/tbjf_pkg.sv =====
// Shared types, constants and fixed-point helpers for the two-body joint force block.
`timescale 1ns / 1ps

package tbjf_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MASS_BITS  = 31;
    localparam int CFG_BITS   = 31;
    localparam int S_DATA_W   = 320;
    localparam int M_DATA_W   = 192;

    localparam int SQRT_STEPS = 32;
    localparam int UDIV_STEPS = 17;
    localparam int WDIV_STEPS = 32;
    localparam int PIPE_DEPTH = 3 + SQRT_STEPS + 1 + UDIV_STEPS + 8 + 1 + WDIV_STEPS + 1;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_REST    = 2'd1;
    localparam logic [1:0] REG_STIFF   = 2'd2;
    localparam logic [1:0] REG_DAMPING = 2'd3;

    typedef enum logic [2:0] {
        MODE_DISTANCE = 3'd0,
        MODE_SPRING   = 3'd1,
        MODE_WELD     = 3'd2,
        MODE_ROPE     = 3'd3,
        MODE_DAMPED   = 3'd4
    } joint_mode_t;

    localparam logic signed [63:0] SAT_HI    = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_LO    = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [63:0] FRAC_MASK = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    // per-item context carried down to the force stages
    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [30:0]        ma;
        logic [30:0]        mb;
    } ctx_t;

    typedef struct packed {
        logic [63:0] n;
        logic [32:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [31:0]        len;
        logic signed [33:0] diff;
        logic               lz;
        logic               ax0;
        logic               ay0;
        logic               sx;
        logic               sy;
        logic [31:0]        rx;
        logic [31:0]        ry;
        logic [16:0]        qx;
        logic [16:0]        qy;
        ctx_t               c;
    } udiv_t;

    // lanes: 0 fx*ma, 1 fx*mb, 2 fy*ma, 3 fy*mb
    typedef struct packed {
        logic [3:0][62:0]   num;
        logic [3:0][31:0]   rem;
        logic [3:0][31:0]   quo;
        logic [31:0]        total;
        logic               weighted;
        logic               sfx;
        logic               sfy;
        logic signed [32:0] fx;
        logic signed [32:0] fy;
        logic               move;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } wdiv_t;

    // divide by 2^FRAC_BITS, rounding toward zero
    function automatic logic signed [63:0] trunc_q(input logic signed [63:0] p);
        return (p + (p[63] ? FRAC_MASK : 64'sd0)) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > SAT_HI) return 32'sh7FFF_FFFF;
        if (v < SAT_LO) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

// ===== hdl/two_body_joint_force.sv =====
// Two-body joint force pipeline: axis, length, unit vector, mode force and mass weighting.
// Throughput: one joint per cycle; the whole pipeline holds while a result waits.
// Depth is set by the 32-step square root, the 17-step unit-vector divide and the
// 32-step mass-share divide, one digit per stage.
// Reset (aresetn low, synchronous) clears all valid bits and the configuration registers.
`timescale 1ns / 1ps

module two_body_joint_force (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [tbjf_pkg::CFG_BITS-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_ax, pos_ay, pos_bx, pos_by, vel_ax, vel_ay, vel_bx, vel_by, mass_a, mass_b, pad
    input  logic [tbjf_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // force_ax, force_ay, force_bx, force_by, new_pos_ax, new_pos_ay
    output logic [tbjf_pkg::M_DATA_W-1:0] m_tdata,
    // move_a
    output logic [0:0]                    m_tuser
);
    import tbjf_pkg::*;

    logic [2:0]          mode_reg;
    logic [30:0]         rest_reg;
    logic [30:0]         stiff_reg;
    logic [30:0]         damp_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                adv;

    assign adv      = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= '0;
            rest_reg  <= '0;
            stiff_reg <= '0;
            damp_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:    mode_reg  <= cfg_wdata[2:0];
                REG_REST:    rest_reg  <= cfg_wdata;
                REG_STIFF:   stiff_reg <= cfg_wdata;
                REG_DAMPING: damp_reg  <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid && s_tready};
        end
    end

    // stage 1: axis and relative velocity
    logic signed [31:0] in_ax, in_ay, in_bx, in_by, in_vax, in_vay, in_vbx, in_vby;
    ctx_t c1_reg, c2_reg;
    logic [63:0] dx2_reg, dy2_reg;

    assign in_ax  = s_tdata[31:0];
    assign in_ay  = s_tdata[63:32];
    assign in_bx  = s_tdata[95:64];
    assign in_by  = s_tdata[127:96];
    assign in_vax = s_tdata[159:128];
    assign in_vay = s_tdata[191:160];
    assign in_vbx = s_tdata[223:192];
    assign in_vby = s_tdata[255:224];

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg.dx  <= sat32(64'(in_bx) - 64'(in_ax));
            c1_reg.dy  <= sat32(64'(in_by) - 64'(in_ay));
            c1_reg.dvx <= 33'(in_vbx) - 33'(in_vax);
            c1_reg.dvy <= 33'(in_vby) - 33'(in_vay);
            c1_reg.bx  <= in_bx;
            c1_reg.by  <= in_by;
            c1_reg.ma  <= s_tdata[286:256];
            c1_reg.mb  <= s_tdata[317:287];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx2_reg <= 64'(c1_reg.dx * c1_reg.dx);
            dy2_reg <= 64'(c1_reg.dy * c1_reg.dy);
            c2_reg  <= c1_reg;
        end
    end

    // square root, two radicand bits per stage
    sqrt_t sq_reg  [SQRT_STEPS+1];
    ctx_t  sqc_reg [SQRT_STEPS+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg[0].n    <= dx2_reg + dy2_reg;
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
            sqc_reg[0]     <= c2_reg;
        end
    end

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        logic [34:0] rsh, trial;
        logic        ge;
        assign rsh   = {sq_reg[i].rem, sq_reg[i].n[63:62]};
        assign trial = {1'b0, sq_reg[i].root, 2'b01};
        assign ge    = rsh >= trial;
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_reg[i+1].n    <= {sq_reg[i].n[61:0], 2'b00};
                sq_reg[i+1].rem  <= ge ? 33'(rsh - trial) : rsh[32:0];
                sq_reg[i+1].root <= {sq_reg[i].root[30:0], ge};
                sqc_reg[i+1]     <= sqc_reg[i];
            end
        end
    end

    // unit vector divide: |d| * 2^16 / len, one quotient bit per stage
    udiv_t       dv_reg [UDIV_STEPS+1];
    logic [31:0] len_w, adx_w, ady_w;
    ctx_t        sqo_w;

    assign len_w = sq_reg[SQRT_STEPS].root;
    assign sqo_w = sqc_reg[SQRT_STEPS];
    assign adx_w = sqo_w.dx[31] ? 32'(-sqo_w.dx) : sqo_w.dx;
    assign ady_w = sqo_w.dy[31] ? 32'(-sqo_w.dy) : sqo_w.dy;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0].len  <= len_w;
            dv_reg[0].diff <= $signed({2'b00, len_w}) - $signed({3'b000, rest_reg});
            dv_reg[0].lz   <= len_w == '0;
            dv_reg[0].ax0  <= adx_w[0];
            dv_reg[0].ay0  <= ady_w[0];
            dv_reg[0].sx   <= sqo_w.dx[31];
            dv_reg[0].sy   <= sqo_w.dy[31];
            dv_reg[0].rx   <= adx_w >> 1;
            dv_reg[0].ry   <= ady_w >> 1;
            dv_reg[0].qx   <= '0;
            dv_reg[0].qy   <= '0;
            dv_reg[0].c    <= sqo_w;
        end
    end

    for (genvar k = 0; k < UDIV_STEPS; k++) begin : g_udiv
        logic [32:0] shx, shy, lz33;
        logic        gex, gey;
        assign shx  = {dv_reg[k].rx, (k == 0) ? dv_reg[k].ax0 : 1'b0};
        assign shy  = {dv_reg[k].ry, (k == 0) ? dv_reg[k].ay0 : 1'b0};
        assign lz33 = {1'b0, dv_reg[k].len};
        assign gex  = shx >= lz33;
        assign gey  = shy >= lz33;
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[k+1].len  <= dv_reg[k].len;
                dv_reg[k+1].diff <= dv_reg[k].diff;
                dv_reg[k+1].lz   <= dv_reg[k].lz;
                dv_reg[k+1].ax0  <= dv_reg[k].ax0;
                dv_reg[k+1].ay0  <= dv_reg[k].ay0;
                dv_reg[k+1].sx   <= dv_reg[k].sx;
                dv_reg[k+1].sy   <= dv_reg[k].sy;
                dv_reg[k+1].c    <= dv_reg[k].c;
                dv_reg[k+1].rx   <= gex ? 32'(shx - lz33) : shx[31:0];
                dv_reg[k+1].ry   <= gey ? 32'(shy - lz33) : shy[31:0];
                dv_reg[k+1].qx   <= {dv_reg[k].qx[15:0], gex};
                dv_reg[k+1].qy   <= {dv_reg[k].qy[15:0], gey};
            end
        end
    end

    // force stages
    udiv_t              dvo_w;
    logic signed [17:0] uxp_w, uyp_w;
    assign dvo_w = dv_reg[UDIV_STEPS];
    assign uxp_w = $signed({1'b0, dvo_w.qx});
    assign uyp_w = $signed({1'b0, dvo_w.qy});

    logic signed [17:0] ux5_reg, uy5_reg, ux6_reg, uy6_reg, ux7_reg, uy7_reg;
    logic signed [17:0] ux8_reg, uy8_reg, ux9_reg, uy9_reg, ux10_reg, uy10_reg;
    logic signed [33:0] diff5_reg, diff6_reg, diff7_reg, diff8_reg, diff9_reg;
    ctx_t               c5_reg, c6_reg, c7_reg, c8_reg, c9_reg;
    logic [30:0]        ma10_reg, mb10_reg, ma11_reg, mb11_reg, ma12_reg, mb12_reg;
    logic signed [63:0] sp6_reg, dmp8_reg;
    logic signed [50:0] pvx6_reg, pvy6_reg;
    logic signed [48:0] wx6_reg, wy6_reg;
    logic signed [31:0] sm7_reg, av7_reg, px7_reg, py7_reg;
    logic signed [31:0] sm8_reg, px8_reg, py8_reg, sm9_reg, dm9_reg, px9_reg, py9_reg;
    logic signed [31:0] mag10_reg, px10_reg, py10_reg, px11_reg, py11_reg, px12_reg, py12_reg;
    logic               act10_reg, wt10_reg, mv10_reg, act11_reg, wt11_reg, mv11_reg;
    logic               wt12_reg, mv12_reg;
    logic signed [49:0] fxp11_reg, fyp11_reg;
    logic signed [32:0] fx12_reg, fy12_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ux5_reg   <= dvo_w.lz ? 18'sd0 : (dvo_w.sx ? -uxp_w : uxp_w);
            uy5_reg   <= dvo_w.lz ? 18'sd0 : (dvo_w.sy ? -uyp_w : uyp_w);
            diff5_reg <= dvo_w.diff;
            c5_reg    <= dvo_w.c;

            sp6_reg   <= 64'(diff5_reg * $signed({1'b0, stiff_reg}));
            pvx6_reg  <= 51'(c5_reg.dvx * ux5_reg);
            pvy6_reg  <= 51'(c5_reg.dvy * uy5_reg);
            wx6_reg   <= 49'($signed({1'b0, rest_reg}) * ux5_reg);
            wy6_reg   <= 49'($signed({1'b0, rest_reg}) * uy5_reg);
            ux6_reg   <= ux5_reg;
            uy6_reg   <= uy5_reg;
            diff6_reg <= diff5_reg;
            c6_reg    <= c5_reg;

            sm7_reg   <= sat32(trunc_q(sp6_reg));
            av7_reg   <= sat32(trunc_q(64'(pvx6_reg) + 64'(pvy6_reg)));
            px7_reg   <= sat32(64'(c6_reg.bx) - trunc_q(64'(wx6_reg)));
            py7_reg   <= sat32(64'(c6_reg.by) - trunc_q(64'(wy6_reg)));
            ux7_reg   <= ux6_reg;
            uy7_reg   <= uy6_reg;
            diff7_reg <= diff6_reg;
            c7_reg    <= c6_reg;

            dmp8_reg  <= 64'(av7_reg * $signed({1'b0, damp_reg}));
            sm8_reg   <= sm7_reg;
            px8_reg   <= px7_reg;
            py8_reg   <= py7_reg;
            ux8_reg   <= ux7_reg;
            uy8_reg   <= uy7_reg;
            diff8_reg <= diff7_reg;
            c8_reg    <= c7_reg;

            dm9_reg   <= sat32(trunc_q(dmp8_reg));
            sm9_reg   <= sm8_reg;
            px9_reg   <= px8_reg;
            py9_reg   <= py8_reg;
            ux9_reg   <= ux8_reg;
            uy9_reg   <= uy8_reg;
            diff9_reg <= diff8_reg;
            c9_reg    <= c8_reg;
        end
    end

    // mode decode
    logic               act_w, wt_w, mv_w;
    logic signed [31:0] mag_w;
    logic               dpos_w, dnz_w;
    assign dpos_w = diff9_reg > 34'sd0;
    assign dnz_w  = diff9_reg != 34'sd0;

    always_comb begin
        act_w = 1'b0;
        wt_w  = 1'b0;
        mv_w  = 1'b0;
        mag_w = sm9_reg;
        unique case (mode_reg)
            MODE_DISTANCE: act_w = dpos_w;
            MODE_SPRING: begin
                act_w = dnz_w;
                wt_w  = 1'b1;
            end
            MODE_WELD:     mv_w = 1'b1;
            MODE_ROPE: begin
                act_w = dpos_w;
                wt_w  = 1'b1;
            end
            MODE_DAMPED: begin
                act_w = dnz_w;
                wt_w  = 1'b1;
                mag_w = sat32(64'(sm9_reg) + 64'(dm9_reg));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag10_reg <= mag_w;
            act10_reg <= act_w;
            wt10_reg  <= wt_w;
            mv10_reg  <= mv_w;
            px10_reg  <= mv_w ? px9_reg : 32'sd0;
            py10_reg  <= mv_w ? py9_reg : 32'sd0;
            ux10_reg  <= ux9_reg;
            uy10_reg  <= uy9_reg;
            ma10_reg  <= c9_reg.ma;
            mb10_reg  <= c9_reg.mb;

            fxp11_reg <= 50'(mag10_reg * ux10_reg);
            fyp11_reg <= 50'(mag10_reg * uy10_reg);
            act11_reg <= act10_reg;
            wt11_reg  <= wt10_reg;
            mv11_reg  <= mv10_reg;
            px11_reg  <= px10_reg;
            py11_reg  <= py10_reg;
            ma11_reg  <= ma10_reg;
            mb11_reg  <= mb10_reg;

            fx12_reg  <= act11_reg ? 33'(trunc_q(64'(fxp11_reg))) : 33'sd0;
            fy12_reg  <= act11_reg ? 33'(trunc_q(64'(fyp11_reg))) : 33'sd0;
            wt12_reg  <= wt11_reg;
            mv12_reg  <= mv11_reg;
            px12_reg  <= px11_reg;
            py12_reg  <= py11_reg;
            ma12_reg  <= ma11_reg;
            mb12_reg  <= mb11_reg;
        end
    end

    // mass share divide: |F| * m / total, four lanes
    wdiv_t       wd_reg [WDIV_STEPS+1];
    logic [31:0] afx_w, afy_w;
    logic [3:0][62:0] num_w;
    assign afx_w = fx12_reg[32] ? 32'(-fx12_reg) : fx12_reg[31:0];
    assign afy_w = fy12_reg[32] ? 32'(-fy12_reg) : fy12_reg[31:0];
    assign num_w[0] = 63'(afx_w * ma12_reg);
    assign num_w[1] = 63'(afx_w * mb12_reg);
    assign num_w[2] = 63'(afy_w * ma12_reg);
    assign num_w[3] = 63'(afy_w * mb12_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            wd_reg[0].num      <= num_w;
            for (int l = 0; l < 4; l++) begin
                wd_reg[0].rem[l] <= {1'b0, num_w[l][62:32]};
            end
            wd_reg[0].quo      <= '0;
            wd_reg[0].total    <= {1'b0, ma12_reg} + {1'b0, mb12_reg};
            wd_reg[0].weighted <= wt12_reg;
            wd_reg[0].sfx      <= fx12_reg[32];
            wd_reg[0].sfy      <= fy12_reg[32];
            wd_reg[0].fx       <= fx12_reg;
            wd_reg[0].fy       <= fy12_reg;
            wd_reg[0].move     <= mv12_reg;
            wd_reg[0].px       <= px12_reg;
            wd_reg[0].py       <= py12_reg;
        end
    end

    for (genvar k = 0; k < WDIV_STEPS; k++) begin : g_wdiv
        for (genvar l = 0; l < 4; l++) begin : g_lane
            logic [32:0] sh, tot33;
            logic        ge;
            assign sh    = {wd_reg[k].rem[l], wd_reg[k].num[l][WDIV_STEPS-1-k]};
            assign tot33 = {1'b0, wd_reg[k].total};
            assign ge    = sh >= tot33;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    wd_reg[k+1].rem[l] <= ge ? 32'(sh - tot33) : sh[31:0];
                    wd_reg[k+1].quo[l] <= {wd_reg[k].quo[l][30:0], ge};
                    wd_reg[k+1].num[l] <= wd_reg[k].num[l];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                wd_reg[k+1].total    <= wd_reg[k].total;
                wd_reg[k+1].weighted <= wd_reg[k].weighted;
                wd_reg[k+1].sfx      <= wd_reg[k].sfx;
                wd_reg[k+1].sfy      <= wd_reg[k].sfy;
                wd_reg[k+1].fx       <= wd_reg[k].fx;
                wd_reg[k+1].fy       <= wd_reg[k].fy;
                wd_reg[k+1].move     <= wd_reg[k].move;
                wd_reg[k+1].px       <= wd_reg[k].px;
                wd_reg[k+1].py       <= wd_reg[k].py;
            end
        end
    end

    // output stage: sign, negate for body B, saturate
    wdiv_t              wo_w;
    logic signed [32:0] wxa_w, wxb_w, wya_w, wyb_w;
    logic signed [31:0] fax_w, fay_w, fbx_w, fby_w;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_move_reg;

    assign wo_w  = wd_reg[WDIV_STEPS];
    assign wxa_w = wo_w.sfx ? -$signed({1'b0, wo_w.quo[0]}) : $signed({1'b0, wo_w.quo[0]});
    assign wxb_w = wo_w.sfx ? -$signed({1'b0, wo_w.quo[1]}) : $signed({1'b0, wo_w.quo[1]});
    assign wya_w = wo_w.sfy ? -$signed({1'b0, wo_w.quo[2]}) : $signed({1'b0, wo_w.quo[2]});
    assign wyb_w = wo_w.sfy ? -$signed({1'b0, wo_w.quo[3]}) : $signed({1'b0, wo_w.quo[3]});

    always_comb begin
        priority if (!wo_w.weighted) begin
            fax_w = sat32(64'(wo_w.fx));
            fay_w = sat32(64'(wo_w.fy));
            fbx_w = sat32(-64'(wo_w.fx));
            fby_w = sat32(-64'(wo_w.fy));
        end else if (wo_w.total == '0) begin
            fax_w = 32'sd0;
            fay_w = 32'sd0;
            fbx_w = 32'sd0;
            fby_w = 32'sd0;
        end else begin
            fax_w = sat32(64'(wxa_w));
            fay_w = sat32(64'(wya_w));
            fbx_w = sat32(-64'(wxb_w));
            fby_w = sat32(-64'(wyb_w));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {wo_w.py, wo_w.px, fby_w, fbx_w, fay_w, fax_w};
            m_move_reg <= wo_w.move;
        end
    end

    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_move_reg;

    a_no_move_no_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[191:128] == '0)
        else $error("new position set without a weld move");

    a_weld_no_force: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[127:0] == '0)
        else $error("weld result carries force");

    a_stall_holds_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> m_tvalid)
        else $error("pending result dropped during stall");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the two-body joint force pipeline.
`timescale 1ns / 1ps

module tb;
    import tbjf_pkg::*;

    typedef struct {
        logic [31:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
        logic [30:0] ma, mb;
    } joint_t;

    typedef struct {
        logic [31:0] fax, fay, fbx, fby;
        logic        move;
        logic [31:0] px, py;
    } force_t;

    class joint_scoreboard;
        logic [2:0]  mode;
        longint      rest, stiff, damp;
        force_t      pending[$];
        int          errors;

        function new();
            mode = '0; rest = 0; stiff = 0; damp = 0; errors = 0;
        endfunction

        function longint clamp(longint v);
            if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
            if (v < -64'sh8000_0000) return -64'sh8000_0000;
            return v;
        endfunction

        function longint root(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function longint share(longint f, longint m, longint total);
            if (total == 0) return 0;
            return f * m / total;
        endfunction

        // predict the result of one accepted joint
        function void note(joint_t j);
            longint ax, ay, bx, by, vax, vay, vbx, vby, ma, mb, dx, dy, len;
            longint ux, uy, diff, mag, total, fax, fay, fbx, fby, px, py, fx, fy;
            longint sm, av, dm;
            longint unsigned sq;
            bit active, weighted, mv;
            force_t e;
            ax = longint'($signed(j.pax)); ay = longint'($signed(j.pay));
            bx = longint'($signed(j.pbx)); by = longint'($signed(j.pby));
            vax = longint'($signed(j.vax)); vay = longint'($signed(j.vay));
            vbx = longint'($signed(j.vbx)); vby = longint'($signed(j.vby));
            ma = longint'(j.ma); mb = longint'(j.mb);
            dx = clamp(bx - ax); dy = clamp(by - ay);
            sq = longint'(dx * dx) + longint'(dy * dy);
            len = root(sq);
            ux = 0; uy = 0; mag = 0; total = ma + mb;
            fax = 0; fay = 0; fbx = 0; fby = 0; px = 0; py = 0;
            active = 0; weighted = 0; mv = 0;
            if (len > 0) begin
                ux = dx * 65536 / len;
                uy = dy * 65536 / len;
            end
            diff = len - rest;
            case (mode)
                MODE_DISTANCE: if (diff > 0) begin
                    mag = clamp(diff * stiff / 65536); active = 1;
                end
                MODE_SPRING: if (diff != 0) begin
                    mag = clamp(diff * stiff / 65536); active = 1; weighted = 1;
                end
                MODE_WELD: begin
                    mv = 1;
                    px = clamp(bx - rest * ux / 65536);
                    py = clamp(by - rest * uy / 65536);
                end
                MODE_ROPE: if (diff > 0) begin
                    mag = clamp(diff * stiff / 65536); active = 1; weighted = 1;
                end
                MODE_DAMPED: if (diff != 0) begin
                    sm = clamp(diff * stiff / 65536);
                    av = clamp(((vbx - vax) * ux + (vby - vay) * uy) / 65536);
                    dm = clamp(av * damp / 65536);
                    mag = clamp(sm + dm);
                    active = 1; weighted = 1;
                end
                default: ;
            endcase
            if (active) begin
                fx = mag * ux / 65536;
                fy = mag * uy / 65536;
                if (weighted) begin
                    fax = share(fx, ma, total); fay = share(fy, ma, total);
                    fbx = -share(fx, mb, total); fby = -share(fy, mb, total);
                end else begin
                    fax = fx; fay = fy; fbx = -fx; fby = -fy;
                end
            end
            e.fax = 32'(clamp(fax)); e.fay = 32'(clamp(fay));
            e.fbx = 32'(clamp(fbx)); e.fby = 32'(clamp(fby));
            e.move = mv; e.px = 32'(px); e.py = 32'(py);
            pending.push_back(e);
        endfunction

        function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(force_t r);
            force_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h %h %h %h %b %h %h", $time,
                         r.fax, r.fay, r.fbx, r.fby, r.move, r.px, r.py);
                errors++;
                return;
            end
            e = pending.pop_front();
            field("force_ax", e.fax, r.fax);
            field("force_ay", e.fay, r.fay);
            field("force_bx", e.fbx, r.fbx);
            field("force_by", e.fby, r.fby);
            field("move_a", {31'd0, e.move}, {31'd0, r.move});
            field("new_pos_ax", e.px, r.px);
            field("new_pos_ay", e.py, r.py);
        endfunction
    endclass

    logic                aclk = 0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [CFG_BITS-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    joint_scoreboard sb = new();
    int snd_idle = 32;
    int rcv_idle = 63;

    two_body_joint_force DUT (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= rcv_idle);

    // handshake inputs only move at the rising edge, so the falling edge sees the transfer
    always @(negedge aclk) begin
        force_t r;
        if (aresetn && m_tvalid && m_tready) begin
            r.fax = m_tdata[31:0];    r.fay = m_tdata[63:32];
            r.fbx = m_tdata[95:64];   r.fby = m_tdata[127:96];
            r.px  = m_tdata[159:128]; r.py  = m_tdata[191:160];
            r.move = m_tuser[0];
            sb.check(r);
        end
    end

    // hold the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_MODE:  sb.mode  = val[2:0];
            REG_REST:  sb.rest  = longint'(val);
            REG_STIFF: sb.stiff = longint'(val);
            default:   sb.damp  = longint'(val);
        endcase
    endtask

    // drain the pipeline, then load a full joint setting
    task automatic set_joint(logic [2:0] mode, logic [30:0] rest, logic [30:0] stiff,
                             logic [30:0] damp);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        write_reg(REG_MODE, {28'd0, mode});
        write_reg(REG_REST, rest);
        write_reg(REG_STIFF, stiff);
        write_reg(REG_DAMPING, damp);
        cfg_wr_en <= 0;
    endtask

    task automatic send_joint(joint_t j);
        bit ok;
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b00, j.mb, j.ma, j.vby, j.vbx, j.vay, j.vax, j.pby, j.pbx, j.pay, j.pax};
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        sb.note(j);
    endtask

    function automatic logic [31:0] rand_word();
        int sc;
        sc = $urandom_range(4, 32);
        return 32'($signed($urandom) >>> (32 - sc));
    endfunction

    function automatic logic [30:0] rand_mass();
        case ($urandom_range(5))
            0: return '0;
            1: return 31'($urandom);
            default: return 31'($urandom >> $urandom_range(1, 30));
        endcase
    endfunction

    function automatic joint_t rand_joint();
        joint_t j;
        if ($urandom_range(9) == 0) begin
            {j.pax, j.pay, j.pbx, j.pby} = {$urandom, $urandom, $urandom, $urandom};
            {j.vax, j.vay, j.vbx, j.vby} = {$urandom, $urandom, $urandom, $urandom};
        end else begin
            j.pax = rand_word(); j.pay = rand_word();
            j.pbx = j.pax + rand_word(); j.pby = j.pay + rand_word();
            j.vax = rand_word(); j.vay = rand_word();
            j.vbx = rand_word(); j.vby = rand_word();
        end
        j.ma = rand_mass(); j.mb = rand_mass();
        return j;
    endfunction

    function automatic joint_t mk(logic [31:0] ax, ay, bx, by, va, vb,
                                  logic [30:0] ma, mb);
        joint_t j;
        j.pax = ax; j.pay = ay; j.pbx = bx; j.pby = by;
        j.vax = va; j.vay = ~va; j.vbx = vb; j.vby = ~vb;
        j.ma = ma; j.mb = mb;
        return j;
    endfunction

    function automatic logic [30:0] rand_cfg();
        case ($urandom_range(4))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom);
            default: return 31'($urandom_range(32'h0100_0000));
        endcase
    endfunction

    initial begin
        joint_t dir[8];
        aresetn <= 0; cfg_wr_en <= 0; cfg_index <= REG_MODE; cfg_wdata <= 0;
        s_tvalid <= 0; s_tdata <= 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        dir[0] = mk(0, 0, 0, 0, 0, 0, 0, 0);
        dir[1] = mk(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
                    32'h0003_0000, 32'h0001_0000, 31'h10000, 31'h10000);
        dir[2] = mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        dir[3] = mk(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0,
                    32'h7FFF_FFFF, 32'h8000_0000, 31'h1, 31'h0);
        dir[4] = mk(0, 0, 32'h0005_0000, 0, 32'hFFFF_0000, 32'h0002_0000, 31'h20000, 31'h10000);
        dir[5] = mk(0, 0, 32'h0000_8000, 32'h0000_8000, 0, 32'h0001_0000, 31'h30000, 0);
        dir[6] = mk(32'h0010_0000, 32'hFFF0_0000, 32'hFFF0_0000, 32'h0010_0000,
                    32'h1234_5678, 32'hEDCB_A987, 0, 31'h40000);
        dir[7] = mk(0, 0, 32'h0003_0000, 0, 32'h0001_0000, 0, 31'h10000, 31'h10000);

        // directed: every mode code over four of the corner cases (one for the undefined codes), rest length 3.0
        for (int m = 0; m < 8; m++) begin
            set_joint(3'(m), 31'h30000, (m == 6) ? 31'h7FFF_FFFF : 31'h20000,
                      (m == 4) ? 31'h18000 : 31'h0);
            for (int k = 0; k < ((m < 5) ? 4 : 1); k++) send_joint(dir[(m + 2 * k) % 8]);
            s_tvalid <= 0;
        end

        for (int ph = 0; ph < 18; ph++) begin
            if (ph == 6) begin snd_idle = 63; rcv_idle = 32; end
            if (ph == 12) begin snd_idle = 0; rcv_idle = 0; end
            set_joint(3'((ph % 9 == 8) ? $urandom_range(5, 7) : ph % 5),
                      rand_cfg(), rand_cfg(), rand_cfg());
            for (int k = 0; k < 85; k++) begin
                send_joint(rand_joint());
            end
            s_tvalid <= 0;
        end

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
